### rtl/slrg_pkg.sv
// Package: shared constants and types for the shuffled Lehmer random generator.
`timescale 1ns / 1ps
`default_nettype none

package slrg_pkg;

  // Shuffle table geometry
  localparam int unsigned TBL_DEPTH = 32;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  // Field widths
  localparam int unsigned SEED_W = 32;
  localparam int unsigned DRAW_W = 31;
  localparam int unsigned MULT_W = 15;
  localparam int unsigned PROD_W = SEED_W + MULT_W;

  // Generator constants: x <- 16807 * x mod (2^31 - 1)
  localparam logic [MULT_W-1:0] LEHMER_MULT  = 15'd16807;
  localparam logic [SEED_W-1:0] LEHMER_MOD   = 32'h7FFF_FFFF;
  localparam logic [SEED_W-1:0] LEHMER_RESET = 32'd10634;

  // Slot select divides the previous output by a power of two
  localparam int unsigned SLOT_DIV   = 1 + (32'h7FFF_FFFE / TBL_DEPTH);
  localparam int unsigned SLOT_SHIFT = $clog2(SLOT_DIV);

  // Warm-up runs eight discarded steps ahead of the table fill
  localparam int unsigned WARM_STEPS = TBL_DEPTH + 8;
  localparam int unsigned CNT_W      = $clog2(WARM_STEPS + 1);

  // Input item modes
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_SEED = 1'b1;

  // Request to the generator step unit
  typedef struct packed {
    logic              en;
    logic [SEED_W-1:0] x;
  } step_req_t;

  // Request to the shuffle table memory
  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [DRAW_W-1:0] wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

endpackage

`default_nettype wire

### rtl/slrg_in_if.sv
// Interfaces: input and result channels of the shuffled Lehmer random generator.
`timescale 1ns / 1ps
`default_nettype none

interface slrg_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [slrg_pkg::SEED_W-1:0] seed_value;

  modport source (output valid, output mode, output seed_value, input ready);
  modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

interface slrg_out_if;
  logic                         valid;
  logic                         ready;
  logic [slrg_pkg::DRAW_W-1:0] draw;

  modport source (output valid, output draw, input ready);
  modport sink   (input valid, input draw, output ready);
endinterface

`default_nettype wire

### rtl/slrg_lehmer_step.sv
// Generator step unit: registered multiply by 16807, then fold mod 2^31 - 1.
`timescale 1ns / 1ps
`default_nettype none

module slrg_lehmer_step (
  input  wire logic                         clk,
  input  wire slrg_pkg::step_req_t         req,
  output logic [slrg_pkg::DRAW_W-1:0]      step_val
);

  logic [slrg_pkg::PROD_W-1:0] prod_r;
  logic [slrg_pkg::SEED_W-1:0] fold_sum;
  logic [slrg_pkg::SEED_W-1:0] fold_sub;

  // Capture the product; it holds until the next request
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= slrg_pkg::PROD_W'(req.x) * slrg_pkg::PROD_W'(slrg_pkg::LEHMER_MULT);
    end
  end

  // 2^31 = 1 mod M: add high part to low part, then one conditional subtract
  always_comb begin
    fold_sum = {1'b0, prod_r[slrg_pkg::DRAW_W-1:0]}
             + slrg_pkg::SEED_W'(prod_r[slrg_pkg::PROD_W-1:slrg_pkg::DRAW_W]);
    fold_sub = fold_sum - slrg_pkg::LEHMER_MOD;
    if (fold_sum >= slrg_pkg::LEHMER_MOD) begin
      step_val = fold_sub[slrg_pkg::DRAW_W-1:0];
    end else begin
      step_val = fold_sum[slrg_pkg::DRAW_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/slrg_table_ram.sv
// Shuffle table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module slrg_table_ram (
  input  wire logic                         clk,
  input  wire slrg_pkg::tbl_req_t          req,
  output logic [slrg_pkg::DRAW_W-1:0]      rd_data
);

  logic [slrg_pkg::DRAW_W-1:0] mem [slrg_pkg::TBL_DEPTH];
  logic [slrg_pkg::DRAW_W-1:0] rd_data_r;

  // Write the entry and register the read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/slrg_ctrl.sv
// Sequencer: generator state, warm-up loop, table read-modify-write and result register.
`timescale 1ns / 1ps
`default_nettype none

module slrg_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  slrg_in_if.sink                           in_ch,
  slrg_out_if.source                        out_ch,
  output slrg_pkg::step_req_t              step_req,
  input  wire logic [slrg_pkg::DRAW_W-1:0] step_val,
  output slrg_pkg::tbl_req_t               tbl_req,
  input  wire logic [slrg_pkg::DRAW_W-1:0] rd_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WMUL = 5'b00010,
    ST_WRED = 5'b00100,
    ST_DMUL = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                       state_r,     state_nxt;
  logic [slrg_pkg::SEED_W-1:0]  lehmer_r,    lehmer_nxt;
  logic [slrg_pkg::DRAW_W-1:0]  last_r,      last_nxt;
  logic [slrg_pkg::CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic [slrg_pkg::SEED_W-1:0]  x_r,         x_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [slrg_pkg::DRAW_W-1:0]  out_draw_r,  out_draw_nxt;

  logic                         accept;
  logic                         draw_acc;
  logic                         need_warm;
  logic                         out_free;
  logic [slrg_pkg::DRAW_W-1:0]  slot_full;
  logic [slrg_pkg::TBL_AW-1:0]  slot;
  logic [slrg_pkg::CNT_W-1:0]   cnt_dec;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.draw  = out_draw_r;

  assign accept    = in_ch.valid && in_ch.ready;
  assign draw_acc  = accept && (in_ch.mode == slrg_pkg::MODE_DRAW);
  assign need_warm = lehmer_r[slrg_pkg::SEED_W-1] || (lehmer_r == '0) || (last_r == '0);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cnt_dec   = cnt_r - slrg_pkg::CNT_W'(1);

  // Pick the slot from the top bits of the previous output, clamped to the table
  always_comb begin
    slot_full = last_r >> slrg_pkg::SLOT_SHIFT;
    if (slot_full >= slrg_pkg::DRAW_W'(slrg_pkg::TBL_DEPTH)) begin
      slot = slrg_pkg::TBL_AW'(slrg_pkg::TBL_DEPTH - 1);
    end else begin
      slot = slot_full[slrg_pkg::TBL_AW-1:0];
    end
  end

  // Next-state logic; reads and writes of the table never overlap in one cycle
  always_comb begin
    state_nxt     = state_r;
    lehmer_nxt    = lehmer_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_draw_nxt  = out_draw_r;

    step_req.en   = 1'b0;
    step_req.x    = (state_r == ST_WMUL) ? x_r : lehmer_r;

    tbl_req.we    = 1'b0;
    tbl_req.waddr = slot;
    tbl_req.wdata = step_val;
    tbl_req.re    = 1'b0;
    tbl_req.raddr = slot;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.mode == slrg_pkg::MODE_SEED)) begin
          lehmer_nxt = in_ch.seed_value;
        end else if (draw_acc && need_warm) begin
          // Seed becomes max(1, -seed)
          x_nxt     = lehmer_r[slrg_pkg::SEED_W-1] ? (~lehmer_r + slrg_pkg::SEED_W'(1))
                                                    : slrg_pkg::SEED_W'(1);
          cnt_nxt   = slrg_pkg::CNT_W'(slrg_pkg::WARM_STEPS);
          state_nxt = ST_WMUL;
        end else if (draw_acc) begin
          step_req.en = 1'b1;
          tbl_req.re  = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_WMUL: begin
        step_req.en = 1'b1;
        state_nxt   = ST_WRED;
      end
      ST_WRED: begin
        // Advance the seed; the last TBL_DEPTH values fill the table top down
        x_nxt         = {1'b0, step_val};
        cnt_nxt       = cnt_dec;
        tbl_req.we    = (cnt_r <= slrg_pkg::CNT_W'(slrg_pkg::TBL_DEPTH));
        tbl_req.waddr = cnt_dec[slrg_pkg::TBL_AW-1:0];
        if (cnt_r == slrg_pkg::CNT_W'(1)) begin
          lehmer_nxt = {1'b0, step_val};
          last_nxt   = step_val;
          state_nxt  = ST_DMUL;
        end else begin
          state_nxt  = ST_WMUL;
        end
      end
      ST_DMUL: begin
        step_req.en = 1'b1;
        tbl_req.re  = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the result register is free, then swap the entry
        if (out_free) begin
          tbl_req.we    = 1'b1;
          out_valid_nxt = 1'b1;
          out_draw_nxt  = rd_data;
          last_nxt      = rd_data;
          lehmer_nxt    = {1'b0, step_val};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lehmer_r    <= slrg_pkg::LEHMER_RESET;
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lehmer_r    <= lehmer_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    out_draw_r <= out_draw_nxt;
  end

endmodule

`default_nettype wire

### rtl/shuffled_lehmer_random_generator.sv
// Top level: shuffled Lehmer random generator with a 32-entry shuffle table.
// Each draw transaction returns one shuffled value of the minimal standard generator
// x <- 16807 * x mod (2^31 - 1); a seed transaction (mode 1) loads the generator value and
// returns nothing. In a draw, the multiply is registered in the step unit and the table
// entry is read, then the product is folded and the entry swapped for the fresh value.
// When the stored seed is zero or negative, or after reset, a draw first runs a warm-up
// of 40 generator steps through the shared step unit, filling the table. The result sits
// in an output register; a draw that finds it still occupied waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lehmer_random_generator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slrg_in_if.sink    in_ch,
  slrg_out_if.source out_ch
);

  slrg_pkg::step_req_t         step_req;
  slrg_pkg::tbl_req_t          tbl_req;
  logic [slrg_pkg::DRAW_W-1:0] step_val;
  logic [slrg_pkg::DRAW_W-1:0] rd_data;

  // Sequencer and state
  slrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .step_req (step_req),
    .step_val (step_val),
    .tbl_req  (tbl_req),
    .rd_data  (rd_data)
  );

  // Generator step unit
  slrg_lehmer_step u_step (
    .clk      (clk),
    .req      (step_req),
    .step_val (step_val)
  );

  // Shuffle table
  slrg_table_ram u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

### rtl/slrg_checker.sv
// Checker: port-level properties of the shuffled Lehmer random generator, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module slrg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_mode,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [slrg_pkg::DRAW_W-1:0] out_draw
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_draw))
    else $error("result changed or dropped while stalled");

  // A draw transaction leaves the block busy, with input ready low, once it is taken
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == slrg_pkg::MODE_DRAW) |=> !in_ready)
    else $error("input taken right after a draw transaction");

  // A seed transaction never yields a result
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == slrg_pkg::MODE_SEED) |=> !$rose(out_valid))
    else $error("result appeared after a seed transaction");

  // A result only appears at the end of a draw, while input was held off
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a draw in progress");

endmodule

bind shuffled_lehmer_random_generator slrg_checker u_slrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_draw  (out_ch.draw)
);

`default_nettype wire
